// ----- rtl/msl_pkg.sv -----
// Shared types, constants and microcode ROM for the mid/side low-cut filter.
`default_nettype none

package msl_pkg;

  // Default sizes handed to the top level parameters.
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int STATE_WIDTH_DEF  = 48;

  // Cascade geometry.
  localparam int NUM_EXTRA = 6;
  localparam int KW        = 3;   // stage counter, holds 0..NUM_EXTRA
  localparam int NSTG      = 8;   // even, odd and the extra stage registers

  // Configuration port.
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 32;
  localparam int COEF_W  = 32;
  localparam int SLOPE_W = 19;
  localparam int WGT_W   = 17;

  localparam logic [CFG_AW-1:0] CFG_BASE_COEF    = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_FLOOR_COEF   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_SLOPE_AMOUNT = 2'd2;

  localparam logic [COEF_W-1:0]  BASE_COEF_RST  = 32'd0;
  localparam logic [COEF_W-1:0]  FLOOR_COEF_RST = 32'd4295;
  localparam logic [SLOPE_W-1:0] SLOPE_RST      = 19'd0;

  // Golden-ratio fraction and its complement, Q0.32.
  localparam logic [COEF_W-1:0] PHI_Q32  = 32'd2654435769;
  localparam logic [COEF_W-1:0] NPHI_Q32 = 32'd1640531527;
  localparam logic [WGT_W-1:0]  ONE_Q16  = 17'h10000;

  // Multiplier and accumulator widths.
  localparam int PROD_W = 64;
  localparam int ACC_W  = 66;

  // Microcode.
  localparam int UPC_W = 5;

  typedef enum logic [1:0] {MA_MLO, MA_MHI, MA_COEF, MA_FLOOR} ma_t;
  typedef enum logic [1:0] {MB_COEF, MB_WGT, MB_PHI, MB_NPHI} mb_t;
  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LOAD, ACC_SHR32, ACC_SHR16, ACC_ADD, ACC_ADDSHL16
  } acc_op_t;
  typedef enum logic [3:0] {
    WB_NONE, WB_MAGD, WB_MAGS, WB_STAGE, WB_TEMP, WB_CORR0, WB_CORR, WB_COEF, WB_OUT
  } wb_op_t;
  typedef enum logic [2:0] {J_NEXT, J_WAIT, J_ALWAYS, J_KNZ, J_KLAST, J_OUT} jmp_t;

  typedef struct packed {
    logic             mul_en;
    ma_t              mul_a;
    mb_t              mul_b;
    acc_op_t          acc;
    wb_op_t           wb;
    logic             k_inc;
    jmp_t             jmp;
    logic [UPC_W-1:0] target;
  } ucw_t;

  // Sequencer to datapath.
  typedef struct packed {
    logic          load;
    logic          mul_en;
    ma_t           mul_a;
    mb_t           mul_b;
    acc_op_t       acc;
    wb_op_t        wb;
    logic [KW-1:0] k;
  } ctrl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic out_blocked;
  } stat_t;

  // Entry points of the program.
  localparam logic [UPC_W-1:0] UC_IDLE   = 5'd0;
  localparam logic [UPC_W-1:0] UC_STAGE  = 5'd1;
  localparam logic [UPC_W-1:0] UC_WEIGHT = 5'd8;
  localparam logic [UPC_W-1:0] UC_OUT    = 5'd17;

  localparam ucw_t UCW_NOP = '{
    mul_en: 1'b0, mul_a: MA_MLO, mul_b: MB_COEF, acc: ACC_HOLD,
    wb: WB_NONE, k_inc: 1'b0, jmp: J_NEXT, target: UC_IDLE
  };

  function automatic ucw_t ucode_rom(input logic [UPC_W-1:0] pc);
    ucw_t w;
    w = UCW_NOP;
    case (pc)
      5'd0: begin                       // wait for a word
        w.jmp = J_WAIT;
      end
      // one-pole stage: s += (t - s) * c / 2^32
      5'd1: w.wb = WB_MAGD;
      5'd2: begin
        w.mul_en = 1'b1; w.mul_a = MA_MLO; w.mul_b = MB_COEF;
      end
      5'd3: begin
        w.mul_en = 1'b1; w.mul_a = MA_MHI; w.mul_b = MB_COEF; w.acc = ACC_SHR32;
      end
      5'd4: w.acc = ACC_ADD;
      5'd5: w.wb = WB_STAGE;
      5'd6: begin
        w.wb = WB_TEMP; w.jmp = J_KNZ; w.target = UC_WEIGHT;
      end
      5'd7: begin                       // first stage feeds the correction directly
        w.wb = WB_CORR0; w.k_inc = 1'b1; w.jmp = J_ALWAYS; w.target = UC_STAGE;
      end
      // weighted stage output: s * w / 2^16
      5'd8: w.wb = WB_MAGS;
      5'd9: begin
        w.mul_en = 1'b1; w.mul_a = MA_MLO; w.mul_b = MB_WGT;
      end
      5'd10: begin
        w.mul_en = 1'b1; w.mul_a = MA_MHI; w.mul_b = MB_WGT; w.acc = ACC_SHR16;
      end
      5'd11: w.acc = ACC_ADDSHL16;
      5'd12: begin
        w.wb = WB_CORR; w.jmp = J_KLAST; w.target = UC_OUT;
      end
      // next coefficient: (c*PHI + floor*(1-PHI)) / 2^32
      5'd13: begin
        w.k_inc = 1'b1; w.mul_en = 1'b1; w.mul_a = MA_COEF; w.mul_b = MB_PHI;
      end
      5'd14: begin
        w.mul_en = 1'b1; w.mul_a = MA_FLOOR; w.mul_b = MB_NPHI; w.acc = ACC_LOAD;
      end
      5'd15: w.acc = ACC_ADD;
      5'd16: begin
        w.wb = WB_COEF; w.jmp = J_ALWAYS; w.target = UC_STAGE;
      end
      5'd17: begin
        w.wb = WB_OUT; w.jmp = J_OUT; w.target = UC_IDLE;
      end
      default: begin
        w.jmp = J_ALWAYS; w.target = UC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/msl_seq.sv -----
// Microcode sequencer: program counter, stage counter and jump logic.
`default_nettype none

module msl_seq
  import msl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output ctrl_t      ctrl
);

  logic [UPC_W-1:0] pc_r, pc_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  ucw_t             uc;
  logic             stall;

  always_comb begin
    uc       = ucode_rom(pc_r);
    in_ready = (uc.jmp == J_WAIT);
    stall    = (uc.jmp == J_OUT) && stat.out_blocked;

    pc_nxt = pc_r + UPC_W'(1);
    case (uc.jmp)
      J_NEXT:   pc_nxt = pc_r + UPC_W'(1);
      J_WAIT:   pc_nxt = in_valid ? pc_r + UPC_W'(1) : pc_r;
      J_ALWAYS: pc_nxt = uc.target;
      J_KNZ:    pc_nxt = (k_r != '0) ? uc.target : pc_r + UPC_W'(1);
      J_KLAST:  pc_nxt = (k_r == KW'(NUM_EXTRA)) ? uc.target : pc_r + UPC_W'(1);
      J_OUT:    pc_nxt = stall ? pc_r : uc.target;
      default:  pc_nxt = UC_IDLE;
    endcase

    k_nxt = k_r;
    if (in_ready && in_valid) begin
      k_nxt = '0;
    end else if (uc.k_inc) begin
      k_nxt = k_r + KW'(1);
    end

    ctrl.load   = in_ready && in_valid;
    ctrl.mul_en = uc.mul_en;
    ctrl.mul_a  = uc.mul_a;
    ctrl.mul_b  = uc.mul_b;
    ctrl.acc    = uc.acc;
    ctrl.wb     = stall ? WB_NONE : uc.wb;
    ctrl.k      = k_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= UC_IDLE;
      k_r  <= '0;
    end else begin
      pc_r <= pc_nxt;
      k_r  <= k_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/msl_dpath.sv -----
// Datapath: config registers, stage registers, shared multiplier, accumulator, output register.
`default_nettype none

module msl_dpath
  import msl_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int STATE_WIDTH  = STATE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire ctrl_t                          ctrl,
  output stat_t                               stat,
  input  wire logic                           cfg_we,
  input  wire logic [CFG_AW-1:0]              cfg_addr,
  input  wire logic [CFG_DW-1:0]              cfg_wdata,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_left,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_right,
  input  wire logic                           in_last,
  input  wire logic                           out_ready,
  output logic                                out_valid,
  output logic signed [SAMPLE_WIDTH-1:0]      out_left,
  output logic signed [SAMPLE_WIDTH-1:0]      out_right,
  output logic                                out_last
);

  localparam int SW   = STATE_WIDTH;
  localparam int SMW  = SAMPLE_WIDTH;
  localparam int FRAC = (SW > SMW + 8) ? (SW - SMW - 8) : 0;
  localparam int DW   = SMW + 1 + FRAC;
  localparam int XW   = ((DW > SW) ? DW : SW) + 1;
  localparam int EW   = ((DW > SW) ? DW : SW) + 2;

  // saturate helpers
  function automatic logic signed [SW-1:0] sat_w1(input logic signed [SW:0] v);
    if (v[SW] != v[SW-1]) return {v[SW], {(SW-1){~v[SW]}}};
    return v[SW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] sat_w2(input logic signed [SW+1:0] v);
    if (!(&v[SW+1:SW-1]) && (|v[SW+1:SW-1])) return {v[SW+1], {(SW-1){~v[SW+1]}}};
    return v[SW-1:0];
  endfunction

  function automatic logic signed [SW-1:0] sat_x(input logic signed [XW-1:0] v);
    if (!(&v[XW-1:SW-1]) && (|v[XW-1:SW-1])) return {v[XW-1], {(SW-1){~v[XW-1]}}};
    return v[SW-1:0];
  endfunction

  function automatic logic signed [SMW-1:0] sat_o(input logic signed [EW-1:0] v);
    if (!(&v[EW-1:SMW-1]) && (|v[EW-1:SMW-1])) return {v[EW-1], {(SMW-1){~v[EW-1]}}};
    return v[SMW-1:0];
  endfunction

  // config
  logic [COEF_W-1:0]  base_r, floor_r;
  logic [SLOPE_W-1:0] slope_r;

  // cascade state
  logic signed [SW-1:0] stg_r [NSTG];
  logic                 flag_r;

  // working registers
  logic signed [SMW:0]   mid_r;
  logic signed [SW-1:0]  side_r, temp_r, corr_r;
  logic [COEF_W-1:0]     coef_r;
  logic [SW-1:0]         mag_r;
  logic                  sgn_r;
  logic [PROD_W-1:0]     prod_r;
  logic [ACC_W-1:0]      acc_r;
  logic                  last_r;

  logic                  out_valid_r;
  logic signed [SMW-1:0] out_left_r, out_right_r;
  logic                  out_last_r;

  // combinational
  logic [KW-1:0]         sel;
  logic signed [SW-1:0]  cur_s;
  logic [SW-1:0]         cur_u;
  logic signed [SW:0]    diff, ndiff;
  logic [SW-1:0]         mag_d, mag_s;
  logic [SW+31:0]        mag_ext;
  logic [SLOPE_W-1:0]    w_start, w_diff;
  logic [WGT_W-1:0]      wgt;
  logic [COEF_W-1:0]     mul_a_v, mul_b_v;
  logic [PROD_W-1:0]     mul_p;
  logic [ACC_W-1:0]      acc_nxt;
  logic [SW-1:0]         acc_s;
  logic signed [SW-1:0]  s_new;
  logic signed [SW+1:0]  corr_term, corr_sum;
  logic signed [SMW:0]   lr_diff;
  logic signed [DW-1:0]  side_raw;
  logic signed [SW-1:0]  side_init;
  logic signed [SW:0]    side_dif;
  logic signed [SW-1:0]  side_fin;
  logic signed [EW-1:0]  mids, sum_l, sum_r;

  always_comb begin
    // stage select: first stage alternates, extra stage k sits at k+1
    if (ctrl.k == '0) begin
      sel = flag_r ? KW'(0) : KW'(1);
    end else begin
      sel = ctrl.k + KW'(1);
    end
    cur_s = stg_r[sel];
    cur_u = cur_s;

    diff  = {temp_r[SW-1], temp_r} - {cur_s[SW-1], cur_s};
    ndiff = -diff;
    mag_d = diff[SW] ? ndiff[SW-1:0] : diff[SW-1:0];
    mag_s = cur_s[SW-1] ? (~cur_u + SW'(1)) : cur_u;

    mag_ext = {32'd0, mag_r};

    // weight of extra stage k: clamp(slope - (k-1), 0, 1) in Q16
    w_start = {ctrl.k - KW'(1), 16'h0000};
    w_diff  = slope_r - w_start;
    if (slope_r > w_start) begin
      wgt = (w_diff > SLOPE_W'(ONE_Q16)) ? ONE_Q16 : w_diff[WGT_W-1:0];
    end else begin
      wgt = '0;
    end

    case (ctrl.mul_a)
      MA_MLO:   mul_a_v = mag_ext[31:0];
      MA_MHI:   mul_a_v = mag_ext[63:32];
      MA_COEF:  mul_a_v = coef_r;
      MA_FLOOR: mul_a_v = floor_r;
      default:  mul_a_v = '0;
    endcase
    case (ctrl.mul_b)
      MB_COEF: mul_b_v = coef_r;
      MB_WGT:  mul_b_v = COEF_W'(wgt);
      MB_PHI:  mul_b_v = PHI_Q32;
      MB_NPHI: mul_b_v = NPHI_Q32;
      default: mul_b_v = '0;
    endcase
    mul_p = PROD_W'(mul_a_v) * PROD_W'(mul_b_v);

    case (ctrl.acc)
      ACC_HOLD:     acc_nxt = acc_r;
      ACC_LOAD:     acc_nxt = ACC_W'(prod_r);
      ACC_SHR32:    acc_nxt = ACC_W'(prod_r >> 32);
      ACC_SHR16:    acc_nxt = ACC_W'(prod_r >> 16);
      ACC_ADD:      acc_nxt = acc_r + ACC_W'(prod_r);
      ACC_ADDSHL16: acc_nxt = acc_r + (ACC_W'(prod_r) << 16);
      default:      acc_nxt = acc_r;
    endcase

    acc_s = acc_r[SW-1:0];
    s_new = sgn_r ? (cur_s + $signed(acc_s)) : (cur_s - $signed(acc_s));

    corr_term = sgn_r ? -$signed({2'b00, acc_s}) : $signed({2'b00, acc_s});
    corr_sum  = {{2{corr_r[SW-1]}}, corr_r} + corr_term;

    // side = (l - r) << FRAC, saturated to the state range
    lr_diff   = {in_left[SMW-1], in_left} - {in_right[SMW-1], in_right};
    side_raw  = DW'(lr_diff) <<< FRAC;
    side_init = sat_x(XW'(side_raw));

    side_dif = {side_r[SW-1], side_r} - {corr_r[SW-1], corr_r};
    side_fin = sat_w1(side_dif);
    mids     = EW'(mid_r) <<< FRAC;
    sum_l    = mids + EW'(side_fin);
    sum_r    = mids - EW'(side_fin);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= BASE_COEF_RST;
      floor_r <= FLOOR_COEF_RST;
      slope_r <= SLOPE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_BASE_COEF:    base_r  <= cfg_wdata[COEF_W-1:0];
        CFG_FLOOR_COEF:   floor_r <= cfg_wdata[COEF_W-1:0];
        CFG_SLOPE_AMOUNT: slope_r <= cfg_wdata[SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTG; i++) begin
        stg_r[i] <= '0;
      end
      flag_r <= 1'b1;
    end else begin
      if (ctrl.wb == WB_STAGE) begin
        stg_r[sel] <= s_new;
      end
      if (ctrl.wb == WB_OUT) begin
        flag_r <= ~flag_r;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= mul_p;
    end
    acc_r <= acc_nxt;
    if (ctrl.load) begin
      mid_r  <= {in_left[SMW-1], in_left} + {in_right[SMW-1], in_right};
      side_r <= side_init;
      temp_r <= side_init;
      coef_r <= base_r;
      last_r <= in_last;
    end
    case (ctrl.wb)
      WB_MAGD: begin
        mag_r <= mag_d;
        sgn_r <= ~diff[SW];
      end
      WB_MAGS: begin
        mag_r <= mag_s;
        sgn_r <= cur_s[SW-1];
      end
      WB_TEMP:  temp_r <= sat_w1(diff);
      WB_CORR0: corr_r <= cur_s;
      WB_CORR:  corr_r <= sat_w2(corr_sum);
      WB_COEF:  coef_r <= acc_r[63:32];
      WB_OUT: begin
        out_left_r  <= sat_o(sum_l >>> (FRAC + 1));
        out_right_r <= sat_o(sum_r >>> (FRAC + 1));
        out_last_r  <= last_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.wb == WB_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.out_blocked = out_valid_r && !out_ready;
  assign out_valid = out_valid_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/midside_side_lowcut_filter_top.sv -----
// Top level of the mid/side low-cut filter: sequencer plus datapath.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+------------------------------------------
//  in_     | in  | tvalid/tready    | tdata {right, left}, tlast = last of block
//  out_    | out | tvalid/tready    | tdata {right_out, left_out}, tlast copied
//  cfg_    | in  | we (no wait)     | addr 0 base, 1 floor, 2 slope; wdata 32 b
//
// Sequencing: an accepted word runs the first stage, then each extra stage
//   with its weighted output, a coefficient step between extra stages, and
//   the output step. The single shared 32x32 multiplier takes magnitude halves
//   in turn; the ROM steps one op a clock except at wait or an output stall.
// Reset: synchronous, active low; clears stage state and the output valid and
//   loads config defaults; the alternate flag starts on the even first stage.
// Stalls: the result sits in an output register; the next word is taken while
//   it waits, and the sequencer holds at its final step only if the previous
//   result has still not been taken.
`default_nettype none

module midside_side_lowcut_filter_top
  import msl_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int STATE_WIDTH  = STATE_WIDTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  // sample_left, sample_right, zero pad to bytes
  input  wire logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    in_tdata,
  input  wire logic                                   in_tlast,
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  // left_out, right_out, zero pad to bytes
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]         out_tdata,
  output logic                                        out_tlast,
  input  wire logic                                   cfg_we,
  input  wire logic [CFG_AW-1:0]                      cfg_addr,
  input  wire logic [CFG_DW-1:0]                      cfg_wdata
);

  localparam int TDW = ((2*SAMPLE_WIDTH+7)/8)*8;

  ctrl_t ctrl;
  stat_t stat;

  logic signed [SAMPLE_WIDTH-1:0] in_left, in_right;
  logic signed [SAMPLE_WIDTH-1:0] out_left, out_right;

  assign in_left  = in_tdata[SAMPLE_WIDTH-1:0];
  assign in_right = in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];

  msl_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  msl_dpath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .STATE_WIDTH  (STATE_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_left   (in_left),
    .in_right  (in_right),
    .in_last   (in_tlast),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_left  (out_left),
    .out_right (out_right),
    .out_last  (out_tlast)
  );

  // pad bits above the two samples read as zero
  assign out_tdata = TDW'({out_right, out_left});

endmodule

`default_nettype wire

// ----- rtl/msl_chk.sv -----
// Port-level checker for the mid/side low-cut filter, bound to the top level.
`default_nettype none

module msl_chk
  import msl_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_tvalid,
  input wire logic                                in_tready,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] out_tdata,
  input wire logic                                out_tlast
);

  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("out word changed while stalled");

  // one word at a time: ready drops right after a word is taken
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while busy");

  // a fresh result posts as the sequencer returns to wait
  a_post_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("result posted while sequencer busy");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("bad state after reset");

endmodule

bind midside_side_lowcut_filter_top msl_chk #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_msl_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
